[rtl/blp_pkg.sv]
// shared types and constants for the blinn-phong lighting block
`timescale 1ns / 1ps
package blp_pkg;

   localparam int IN_W      = 16;
   localparam int CH_W      = 16;
   localparam int RGB_W     = 48;
   localparam int SHINE_W   = 10;
   localparam int DNL_W     = 34;
   localparam int PNS_W     = 35;
   localparam int Q_W       = 34;
   localparam int SQ_IN_W   = Q_W + 16;
   localparam int ROOT_W    = SQ_IN_W / 2;
   localparam int CFG_IDX_W = 3;
   localparam int Q_DEPTH   = 8;
   localparam int Q_PTR_W   = 3;
   localparam int FRONT_STAGES = 3;

   localparam logic [CFG_IDX_W-1:0] REG_MAT_AMB  = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_MAT_DIF  = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_MAT_SPC  = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_LGT_AMB  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_LGT_DIF  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_LGT_SPC  = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_SHINE    = 3'd6;

   localparam logic [SHINE_W-1:0] SHINE_RESET = 10'd32;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [DNL_W-1:0] dnl;
      logic signed [PNS_W-1:0] pns;
      logic [Q_W-1:0]          q;
   } dots_type;

   typedef struct packed {
      logic [RGB_W-1:0]   mat_amb;
      logic [RGB_W-1:0]   mat_dif;
      logic [RGB_W-1:0]   mat_spc;
      logic [RGB_W-1:0]   lgt_amb;
      logic [RGB_W-1:0]   lgt_dif;
      logic [RGB_W-1:0]   lgt_spc;
      logic [SHINE_W-1:0] shine;
   } cfg_type;

endpackage

[rtl/blp_front.sv]
// front end: captures vectors and forms the raw dot products
`timescale 1ns / 1ps
module blp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  blp_pkg::vec_type  n_vec,
   input  blp_pkg::vec_type  l_vec,
   input  blp_pkg::vec_type  v_vec,
   output logic              push,
   output blp_pkg::dots_type dots
);
   import blp_pkg::*;

   logic v1_ff, v2_ff, push_ff;
   logic signed [IN_W-1:0] n1_ff [3];
   logic signed [IN_W-1:0] l1_ff [3];
   logic signed [IN_W:0]   s1_ff [3];
   logic signed [2*IN_W-1:0] pnl_ff [3];
   logic signed [2*IN_W:0]   pns_ff [3];
   logic [2*IN_W:0]          pss_ff [3];
   logic signed [2*IN_W+1:0] sq_full [3];
   dots_type dots_ff, dots_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         push_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         push_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      n1_ff[0] <= n_vec.x;
      n1_ff[1] <= n_vec.y;
      n1_ff[2] <= n_vec.z;
      l1_ff[0] <= l_vec.x;
      l1_ff[1] <= l_vec.y;
      l1_ff[2] <= l_vec.z;
      s1_ff[0] <= (IN_W+1)'(l_vec.x) + (IN_W+1)'(v_vec.x);
      s1_ff[1] <= (IN_W+1)'(l_vec.y) + (IN_W+1)'(v_vec.y);
      s1_ff[2] <= (IN_W+1)'(l_vec.z) + (IN_W+1)'(v_vec.z);
   end

   for (genvar i = 0; i < 3; i++) begin : g_prod
      assign sq_full[i] = s1_ff[i] * s1_ff[i];
      always_ff @(posedge clock) begin
         pnl_ff[i] <= n1_ff[i] * l1_ff[i];
         pns_ff[i] <= n1_ff[i] * s1_ff[i];
         pss_ff[i] <= sq_full[i][2*IN_W:0];
      end
   end

   always_comb begin
      dots_in.dnl = DNL_W'(pnl_ff[0]) + DNL_W'(pnl_ff[1]) + DNL_W'(pnl_ff[2]);
      dots_in.pns = PNS_W'(pns_ff[0]) + PNS_W'(pns_ff[1]) + PNS_W'(pns_ff[2]);
      dots_in.q   = Q_W'(pss_ff[0]) + Q_W'(pss_ff[1]) + Q_W'(pss_ff[2]);
   end

   always_ff @(posedge clock) begin
      dots_ff <= dots_in;
   end

   assign push = push_ff;
   assign dots = dots_ff;

endmodule

[rtl/blp_queue.sv]
// short transaction queue between front and back
`timescale 1ns / 1ps
module blp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  blp_pkg::dots_type push_data,
   input  logic              pop,
   output logic              not_empty,
   output logic              near_full,
   output blp_pkg::dots_type pop_data
);
   import blp_pkg::*;

   dots_type mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, rd_ff;
   logic [Q_PTR_W:0]   level_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         level_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         level_ff <= level_ff + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
      end
   end

   assign not_empty = (level_ff != '0);
   assign near_full = (level_ff >= (Q_PTR_W+1)'(Q_DEPTH - FRONT_STAGES));
   assign pop_data  = mem_ff[rd_ff];

endmodule

[rtl/blp_back.sv]
// back end: half-vector root, divide, power and color combine
`timescale 1ns / 1ps
module blp_back #(
   parameter int FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  blp_pkg::dots_type         dots,
   input  blp_pkg::cfg_type          cfg,
   output logic                      out_valid,
   output logic [blp_pkg::CH_W-1:0]  red,
   output logic [blp_pkg::CH_W-1:0]  green,
   output logic [blp_pkg::CH_W-1:0]  blue,
   output logic                      degenerate
);
   import blp_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int MAG_W  = PNS_W - 1;
   localparam int DIV_W  = PNS_W + F + 8;
   localparam int KP_W   = 2*CH_W - F;
   localparam int TRM_W  = KP_W + 1;
   localparam int SUM_W  = TRM_W + 2;
   localparam logic [F:0] ONE_N = (F+1)'(1) << F;
   localparam logic [F:0] HALF_N = (F+1)'(1) << (F-1);

   typedef struct packed {
      logic             vld;
      logic             dgn;
      logic             pos;
      logic [F:0]       ndotl;
      logic [MAG_W-1:0] pmag;
   } meta_type;

   // stage 0: classify
   meta_type m0_in;
   logic [DNL_W-1:0] dnl_sh;
   assign dnl_sh = dots.dnl >>> F;

   always_comb begin
      m0_in.vld = in_valid;
      m0_in.dgn = (dots.q == '0);
      m0_in.pos = (dots.pns > 0);
      m0_in.pmag = dots.pns[MAG_W-1:0];
      if (dots.dnl > 0) begin
         m0_in.ndotl = (dnl_sh > DNL_W'(ONE_N)) ? ONE_N : dnl_sh[F:0];
      end else begin
         m0_in.ndotl = '0;
      end
   end

   // square root pipeline
   meta_type sm_ff [ROOT_W+1];
   logic [SQ_IN_W-1:0] sv_ff [ROOT_W+1];
   logic [SQ_IN_W-1:0] sr_ff [ROOT_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_ff[0].vld <= 1'b0;
      end else begin
         sm_ff[0].vld <= m0_in.vld;
      end
      sm_ff[0].dgn <= m0_in.dgn;
      sm_ff[0].pos <= m0_in.pos;
      sm_ff[0].ndotl <= m0_in.ndotl;
      sm_ff[0].pmag <= m0_in.pmag;
      sv_ff[0] <= {dots.q, 16'b0};
      sr_ff[0] <= '0;
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      localparam logic [SQ_IN_W-1:0] BIT = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2*i);
      logic [SQ_IN_W-1:0] trial;
      assign trial = sr_ff[i] + BIT;
      always_ff @(posedge clock) begin
         if (reset) begin
            sm_ff[i+1].vld <= 1'b0;
         end else begin
            sm_ff[i+1].vld <= sm_ff[i].vld;
         end
         sm_ff[i+1].dgn <= sm_ff[i].dgn;
         sm_ff[i+1].pos <= sm_ff[i].pos;
         sm_ff[i+1].ndotl <= sm_ff[i].ndotl;
         sm_ff[i+1].pmag <= sm_ff[i].pmag;
         if (sv_ff[i] >= trial) begin
            sv_ff[i+1] <= sv_ff[i] - trial;
            sr_ff[i+1] <= (sr_ff[i] >> 1) + BIT;
         end else begin
            sv_ff[i+1] <= sv_ff[i];
            sr_ff[i+1] <= sr_ff[i] >> 1;
         end
      end
   end

   // divider pipeline
   logic [ROOT_W-1:0] root;
   logic [DIV_W-1:0]  dividend;
   assign root = sr_ff[ROOT_W][ROOT_W-1:0];
   assign dividend = sm_ff[ROOT_W].pos ? DIV_W'({sm_ff[ROOT_W].pmag, 8'b0}) : '0;

   meta_type dm_ff [F+2];
   logic [DIV_W-1:0]  drem_ff [F+2];
   logic [ROOT_W-1:0] dden_ff [F+2];
   logic [F:0]        dquo_ff [F+2];
   logic              dovf_ff [F+2];

   always_ff @(posedge clock) begin
      if (reset) begin
         dm_ff[0].vld <= 1'b0;
      end else begin
         dm_ff[0].vld <= sm_ff[ROOT_W].vld;
      end
      dm_ff[0].dgn <= sm_ff[ROOT_W].dgn;
      dm_ff[0].pos <= sm_ff[ROOT_W].pos;
      dm_ff[0].ndotl <= sm_ff[ROOT_W].ndotl;
      dm_ff[0].pmag <= sm_ff[ROOT_W].pmag;
      drem_ff[0] <= dividend;
      dden_ff[0] <= root;
      dquo_ff[0] <= '0;
      dovf_ff[0] <= (dividend >= (DIV_W'(root) << (F+1)));
   end

   for (genvar j = 0; j <= F; j++) begin : g_div
      logic [DIV_W-1:0] sub;
      assign sub = DIV_W'(dden_ff[j]) << (F - j);
      always_ff @(posedge clock) begin
         if (reset) begin
            dm_ff[j+1].vld <= 1'b0;
         end else begin
            dm_ff[j+1].vld <= dm_ff[j].vld;
         end
         dm_ff[j+1].dgn <= dm_ff[j].dgn;
         dm_ff[j+1].pos <= dm_ff[j].pos;
         dm_ff[j+1].ndotl <= dm_ff[j].ndotl;
         dm_ff[j+1].pmag <= dm_ff[j].pmag;
         dden_ff[j+1] <= dden_ff[j];
         dovf_ff[j+1] <= dovf_ff[j];
         if (drem_ff[j] >= sub) begin
            drem_ff[j+1] <= drem_ff[j] - sub;
            dquo_ff[j+1] <= dquo_ff[j] | ((F+1)'(1) << (F - j));
         end else begin
            drem_ff[j+1] <= drem_ff[j];
            dquo_ff[j+1] <= dquo_ff[j];
         end
      end
   end

   // power pipeline
   logic [F:0] ndoth;
   assign ndoth = (dovf_ff[F+1] || (dquo_ff[F+1] > ONE_N)) ? ONE_N : dquo_ff[F+1];

   meta_type pm_ff [SHINE_W+1];
   logic [F:0]         pbase_ff [SHINE_W+1];
   logic [F:0]         pacc_ff  [SHINE_W+1];
   logic [SHINE_W-1:0] pexp_ff  [SHINE_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff[0].vld <= 1'b0;
      end else begin
         pm_ff[0].vld <= dm_ff[F+1].vld;
      end
      pm_ff[0].dgn <= dm_ff[F+1].dgn;
      pm_ff[0].pos <= dm_ff[F+1].pos;
      pm_ff[0].ndotl <= dm_ff[F+1].ndotl;
      pm_ff[0].pmag <= dm_ff[F+1].pmag;
      pbase_ff[0] <= ndoth;
      pacc_ff[0] <= ONE_N;
      pexp_ff[0] <= cfg.shine;
   end

   for (genvar k = 0; k < SHINE_W; k++) begin : g_pow
      logic [2*F+1:0] acc_prod, base_prod;
      logic [2*F+1:0] acc_rnd, base_rnd;
      assign acc_prod  = pacc_ff[k] * pbase_ff[k];
      assign base_prod = pbase_ff[k] * pbase_ff[k];
      assign acc_rnd   = (acc_prod + (2*F+2)'(HALF_N)) >> F;
      assign base_rnd  = (base_prod + (2*F+2)'(HALF_N)) >> F;
      always_ff @(posedge clock) begin
         if (reset) begin
            pm_ff[k+1].vld <= 1'b0;
         end else begin
            pm_ff[k+1].vld <= pm_ff[k].vld;
         end
         pm_ff[k+1].dgn <= pm_ff[k].dgn;
         pm_ff[k+1].pos <= pm_ff[k].pos;
         pm_ff[k+1].ndotl <= pm_ff[k].ndotl;
         pm_ff[k+1].pmag <= pm_ff[k].pmag;
         pexp_ff[k+1] <= pexp_ff[k];
         pbase_ff[k+1] <= base_rnd[F:0];
         pacc_ff[k+1] <= pexp_ff[k][k] ? acc_rnd[F:0] : pacc_ff[k];
      end
   end

   logic [F:0] pw;
   assign pw = pm_ff[SHINE_W].dgn ? '0 : pacc_ff[SHINE_W];

   // color combine
   logic [KP_W-1:0]  amb_ff [3];
   logic [KP_W-1:0]  kdi_ff [3];
   logic [KP_W-1:0]  ksi_ff [3];
   logic [TRM_W-1:0] dt_ff  [3];
   logic [TRM_W-1:0] st_ff  [3];
   logic [KP_W-1:0]  am1_ff [3];
   logic [CH_W-1:0]  col_ff [3];
   logic f1_vld_ff, f1_dgn_ff, out_vld_ff, out_dgn_ff;

   for (genvar c = 0; c < 3; c++) begin : g_chan
      logic [2*CH_W-1:0] pa, pd, ps;
      logic [KP_W+F:0]   md, ms;
      logic [SUM_W-1:0]  sum;
      assign pa  = cfg.mat_amb[CH_W*c +: CH_W] * cfg.lgt_amb[CH_W*c +: CH_W];
      assign pd  = cfg.mat_dif[CH_W*c +: CH_W] * cfg.lgt_dif[CH_W*c +: CH_W];
      assign ps  = cfg.mat_spc[CH_W*c +: CH_W] * cfg.lgt_spc[CH_W*c +: CH_W];
      assign md  = kdi_ff[c] * pm_ff[SHINE_W].ndotl;
      assign ms  = ksi_ff[c] * pw;
      assign sum = SUM_W'(am1_ff[c]) + SUM_W'(dt_ff[c]) + SUM_W'(st_ff[c]);
      always_ff @(posedge clock) begin
         amb_ff[c] <= pa[2*CH_W-1:F];
         kdi_ff[c] <= pd[2*CH_W-1:F];
         ksi_ff[c] <= ps[2*CH_W-1:F];
         dt_ff[c]  <= md[KP_W+F:F];
         st_ff[c]  <= ms[KP_W+F:F];
         am1_ff[c] <= amb_ff[c];
         col_ff[c] <= (sum > SUM_W'({CH_W{1'b1}})) ? {CH_W{1'b1}} : sum[CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= pm_ff[SHINE_W].vld;
         out_vld_ff <= f1_vld_ff;
      end
      f1_dgn_ff <= pm_ff[SHINE_W].dgn;
      out_dgn_ff <= f1_dgn_ff;
   end

   assign out_valid  = out_vld_ff;
   assign red        = col_ff[0];
   assign green      = col_ff[1];
   assign blue       = col_ff[2];
   assign degenerate = out_dgn_ff;

endmodule

[rtl/blinn_phong_lighting.sv]
// Blinn-Phong lighting top level: one fragment per clock, fully pipelined.
// A transaction is taken whenever start is high and busy is low; busy stays low in
// steady streaming, so one fragment can enter every cycle. Each result appears
// on rsp_valid for one cycle; the pipeline holds the 25-stage square root of
// |L+V|^2, the FRAC_BITS + 1 stage divider for N.H and the 10-stage exponent
// pipeline. Results cannot be held off. Registers are written through the csr port;
// the user must do so only while no transaction is in flight; no check enforces it.
`timescale 1ns / 1ps
module blinn_phong_lighting #(
   parameter int FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [blp_pkg::IN_W-1:0]   req_normal_x,
   input  logic signed [blp_pkg::IN_W-1:0]   req_normal_y,
   input  logic signed [blp_pkg::IN_W-1:0]   req_normal_z,
   input  logic signed [blp_pkg::IN_W-1:0]   req_light_dir_x,
   input  logic signed [blp_pkg::IN_W-1:0]   req_light_dir_y,
   input  logic signed [blp_pkg::IN_W-1:0]   req_light_dir_z,
   input  logic signed [blp_pkg::IN_W-1:0]   req_view_dir_x,
   input  logic signed [blp_pkg::IN_W-1:0]   req_view_dir_y,
   input  logic signed [blp_pkg::IN_W-1:0]   req_view_dir_z,
   output logic                              rsp_valid,
   output logic [blp_pkg::CH_W-1:0]          rsp_color_red,
   output logic [blp_pkg::CH_W-1:0]          rsp_color_green,
   output logic [blp_pkg::CH_W-1:0]          rsp_color_blue,
   output logic                              rsp_degenerate_half,
   input  logic                              csr_we,
   input  logic [blp_pkg::CFG_IDX_W-1:0]     csr_index,
   input  logic [blp_pkg::RGB_W-1:0]         csr_wdata
);
   import blp_pkg::*;

   cfg_type  cfg_ff;
   vec_type  n_vec, l_vec, v_vec;
   dots_type front_dots, queue_dots;
   logic     accept, push, not_empty, near_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mat_amb <= '0;
         cfg_ff.mat_dif <= '0;
         cfg_ff.mat_spc <= '0;
         cfg_ff.lgt_amb <= '0;
         cfg_ff.lgt_dif <= '0;
         cfg_ff.lgt_spc <= '0;
         cfg_ff.shine   <= SHINE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAT_AMB: cfg_ff.mat_amb <= csr_wdata;
            REG_MAT_DIF: cfg_ff.mat_dif <= csr_wdata;
            REG_MAT_SPC: cfg_ff.mat_spc <= csr_wdata;
            REG_LGT_AMB: cfg_ff.lgt_amb <= csr_wdata;
            REG_LGT_DIF: cfg_ff.lgt_dif <= csr_wdata;
            REG_LGT_SPC: cfg_ff.lgt_spc <= csr_wdata;
            REG_SHINE:   cfg_ff.shine   <= csr_wdata[SHINE_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy   = near_full;
   assign accept = start && !busy;

   assign n_vec = '{x: req_normal_x, y: req_normal_y, z: req_normal_z};
   assign l_vec = '{x: req_light_dir_x, y: req_light_dir_y, z: req_light_dir_z};
   assign v_vec = '{x: req_view_dir_x, y: req_view_dir_y, z: req_view_dir_z};

   blp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .n_vec    (n_vec),
      .l_vec    (l_vec),
      .v_vec    (v_vec),
      .push     (push),
      .dots     (front_dots)
   );

   blp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_dots),
      .pop       (not_empty),
      .not_empty (not_empty),
      .near_full (near_full),
      .pop_data  (queue_dots)
   );

   blp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (not_empty),
      .dots       (queue_dots),
      .cfg        (cfg_ff),
      .out_valid  (rsp_valid),
      .red        (rsp_color_red),
      .green      (rsp_color_green),
      .blue       (rsp_color_blue),
      .degenerate (rsp_degenerate_half)
   );

endmodule
